FILE: hdl/bwe_pkg.sv
// ----------------------------------------------------------------------------
// bwe_pkg
// Types and constants shared by the Butterworth emphasis gain pipeline.
// ----------------------------------------------------------------------------
package bwe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_DIM   = 1024;

    localparam int CFG_W   = 11;
    localparam int IDX_W   = 10;
    localparam int ORD_W   = 4;
    localparam int PCT_W   = 9;
    localparam int DIST_W  = 21;
    localparam int Q_W     = 22;
    localparam int WORD_W  = 32;
    localparam int PROD_W  = WORD_W + Q_W;
    localparam int SH_W    = 6;
    localparam int GPCT_W  = 19;
    localparam int W_W     = FRAC_BITS + 1;
    localparam int GAIN_W  = FRAC_BITS + 2;
    localparam int DEN_W   = WORD_W + 1;

    // one weight step per unit of the largest order value
    localparam int NUM_STEPS = (1 << ORD_W) - 1;
    // input reg + 2 distance stages + 2 per step + divider + gain/product
    localparam int LATENCY   = 3 + 2 * NUM_STEPS + W_W + 4;

    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

    // register indexes on the configuration port
    localparam logic [2:0] REG_ROWS  = 3'd0;
    localparam logic [2:0] REG_COLS  = 3'd1;
    localparam logic [2:0] REG_CUT   = 3'd2;
    localparam logic [2:0] REG_ORDER = 3'd3;
    localparam logic [2:0] REG_HIGH  = 3'd4;
    localparam logic [2:0] REG_LOW   = 3'd5;

    localparam logic [CFG_W-1:0] ROWS_RST  = 11'd512;
    localparam logic [CFG_W-1:0] COLS_RST  = 11'd512;
    localparam logic [CFG_W-1:0] CUT_RST   = 11'd10;
    localparam logic [ORD_W-1:0] ORDER_RST = 4'd2;
    localparam logic [PCT_W-1:0] HIGH_RST  = 9'd100;
    localparam logic [PCT_W-1:0] LOW_RST   = 9'd30;

    typedef struct packed {
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
        logic [WORD_W-1:0] spectrum_value;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] filtered_value;
        logic              saturated;
    } result_t;

    // derived settings handed to the datapath
    typedef struct packed {
        logic [IDX_W-1:0]  centre_row;
        logic [IDX_W-1:0]  centre_col;
        logic [Q_W-1:0]    cut_sq;
        logic [ORD_W-1:0]  order;
        logic [GPCT_W-1:0] gain_high;
        logic [GPCT_W-1:0] gain_low;
    } cfg_t;

    typedef struct packed {
        logic              d_zero;
        logic [WORD_W-1:0] sample;
    } carry_t;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [DIST_W-1:0] d;
        carry_t            carry;
    } wstate_t;

endpackage

FILE: hdl/bwe_cfg.sv
// ----------------------------------------------------------------------------
// bwe_cfg
// Configuration registers and the settings derived from them.
// ----------------------------------------------------------------------------
module bwe_cfg
    import bwe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg
);

    localparam logic [25:0] RECIP_100 = 26'd42949673;   // ceil(2^32 / 100)

    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] cut_reg;
    logic [ORD_W-1:0] order_reg;
    logic [PCT_W-1:0] high_reg;
    logic [PCT_W-1:0] low_reg;
    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [CFG_W-1:0] rows_c;
    logic [CFG_W-1:0] cols_c;

    // round(pct * 2^F / 100), halves up, by reciprocal multiply
    function automatic logic [GPCT_W-1:0] pct_to_gain(input logic [PCT_W-1:0] pct);
        logic [24:0] x;
        logic [50:0] p;
        x = (25'(pct) << FRAC_BITS) + 25'd50;
        p = 51'(x) * 51'(RECIP_100);
        return p[50:32];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= ROWS_RST;
            cols_reg  <= COLS_RST;
            cut_reg   <= CUT_RST;
            order_reg <= ORDER_RST;
            high_reg  <= HIGH_RST;
            low_reg   <= LOW_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROWS:  rows_reg  <= cfg_data;
                REG_COLS:  cols_reg  <= cfg_data;
                REG_CUT:   cut_reg   <= cfg_data;
                REG_ORDER: order_reg <= cfg_data[ORD_W-1:0];
                REG_HIGH:  high_reg  <= cfg_data[PCT_W-1:0];
                REG_LOW:   low_reg   <= cfg_data[PCT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        rows_c = (rows_reg > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : rows_reg;
        cols_c = (cols_reg > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : cols_reg;
        cfg_next.centre_row = rows_c[CFG_W-1:1];
        cfg_next.centre_col = cols_c[CFG_W-1:1];
        cfg_next.cut_sq     = Q_W'(cut_reg) * Q_W'(cut_reg);
        cfg_next.order      = order_reg;
        cfg_next.gain_high  = pct_to_gain(high_reg);
        cfg_next.gain_low   = pct_to_gain(low_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.centre_row <= ROWS_RST[CFG_W-1:1];
            cfg_reg.centre_col <= COLS_RST[CFG_W-1:1];
            cfg_reg.cut_sq     <= Q_W'(CUT_RST) * Q_W'(CUT_RST);
            cfg_reg.order      <= ORDER_RST;
            cfg_reg.gain_high  <= GPCT_W'(((int'(HIGH_RST) << FRAC_BITS) + 50) / 100);
            cfg_reg.gain_low   <= GPCT_W'(((int'(LOW_RST) << FRAC_BITS) + 50) / 100);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/bwe_dist.sv
// ----------------------------------------------------------------------------
// bwe_dist
// Input register and squared distance from the spectrum centre.
// ----------------------------------------------------------------------------
module bwe_dist
    import bwe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  item_t   item,
    input  cfg_t    cfg,
    output logic    out_valid,
    output wstate_t out_state
);

    logic             va_reg;
    logic             vb_reg;
    logic             vc_reg;
    item_t            item_reg;
    logic [IDX_W-1:0] dr_reg;
    logic [IDX_W-1:0] dc_reg;
    logic [IDX_W-1:0] dr_next;
    logic [IDX_W-1:0] dc_next;
    logic [WORD_W-1:0] sample_b_reg;
    wstate_t          st_reg;
    wstate_t          st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= accept;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_comb
    begin
        dr_next = (item_reg.row_index >= cfg.centre_row) ?
                  item_reg.row_index - cfg.centre_row : cfg.centre_row - item_reg.row_index;
        dc_next = (item_reg.col_index >= cfg.centre_col) ?
                  item_reg.col_index - cfg.centre_col : cfg.centre_col - item_reg.col_index;
        st_next.a            = WORD_W'(1);
        st_next.b            = WORD_W'(1);
        st_next.d            = DIST_W'(dr_reg) * DIST_W'(dr_reg)
                             + DIST_W'(dc_reg) * DIST_W'(dc_reg);
        st_next.carry.d_zero = (dr_reg == '0) && (dc_reg == '0);
        st_next.carry.sample = sample_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        dr_reg       <= dr_next;
        dc_reg       <= dc_next;
        sample_b_reg <= item_reg.spectrum_value;
        st_reg       <= st_next;
    end

    assign out_valid = vc_reg;
    assign out_state = st_reg;

endmodule

FILE: hdl/bwe_wstep.sv
// ----------------------------------------------------------------------------
// bwe_wstep
// One power step of the weight ratio: multiply while the step is below the order, then renormalize to 32 bits.
// ----------------------------------------------------------------------------
module bwe_wstep
    import bwe_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  wstate_t          in_state,
    input  logic [ORD_W-1:0] order,
    input  logic [Q_W-1:0]   cut_sq,
    output logic             out_valid,
    output wstate_t          out_state
);

    logic              vm_reg;
    logic              vn_reg;
    logic [PROD_W-1:0] am_reg;
    logic [PROD_W-1:0] bm_reg;
    logic [PROD_W-1:0] am_next;
    logic [PROD_W-1:0] bm_next;
    logic [DIST_W-1:0] dm_reg;
    carry_t            cm_reg;
    logic [PROD_W-1:0] both;
    logic [SH_W-1:0]   len;
    logic [SH_W-1:0]   sh;
    wstate_t           st_reg;
    wstate_t           st_next;

    always_comb
    begin
        if (ORD_W'(STEP) < order)
        begin
            am_next = PROD_W'(in_state.a) * PROD_W'(in_state.d);
            bm_next = PROD_W'(in_state.b) * PROD_W'(cut_sq);
        end
        else
        begin
            am_next = PROD_W'(in_state.a);
            bm_next = PROD_W'(in_state.b);
        end
    end

    // shift both right until the larger fits in a word
    always_comb
    begin
        both = am_reg | bm_reg;
        len  = '0;
        for (int i = 0; i < PROD_W; i++)
        begin
            if (both[i])
                len = SH_W'(i + 1);
        end
        sh = (len > SH_W'(WORD_W)) ? len - SH_W'(WORD_W) : '0;
        st_next.a     = WORD_W'(am_reg >> sh);
        st_next.b     = WORD_W'(bm_reg >> sh);
        st_next.d     = dm_reg;
        st_next.carry = cm_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            vn_reg <= 1'b0;
        end
        else
        begin
            vm_reg <= in_valid;
            vn_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        am_reg <= am_next;
        bm_reg <= bm_next;
        dm_reg <= in_state.d;
        cm_reg <= in_state.carry;
        st_reg <= st_next;
    end

    assign out_valid = vn_reg;
    assign out_state = st_reg;

endmodule

FILE: hdl/bwe_div.sv
// ----------------------------------------------------------------------------
// bwe_div
// Pipelined restoring divider: w = floor(a * 2^F / (a + b)), one bit a stage.
// ----------------------------------------------------------------------------
module bwe_div
    import bwe_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  wstate_t        in_state,
    output logic           out_valid,
    output logic [W_W-1:0] weight,
    output carry_t         out_carry
);

    logic [W_W-1:0]   v_reg;
    logic [DEN_W-1:0] rem_reg  [W_W];
    logic [DEN_W-1:0] den_reg  [W_W];
    logic [W_W-1:0]   quo_reg  [W_W];
    logic             dz_reg   [W_W];
    carry_t           car_reg  [W_W];
    logic [DEN_W-1:0] rem_next [W_W];
    logic [W_W-1:0]   quo_next [W_W];
    logic [DEN_W-1:0] den0;
    logic [DEN_W:0]   shifted;

    always_comb
    begin
        den0 = DEN_W'(in_state.a) + DEN_W'(in_state.b);
        // top quotient bit: a against the full divisor
        if (DEN_W'(in_state.a) >= den0)
        begin
            rem_next[0] = DEN_W'(in_state.a) - den0;
            quo_next[0] = W_W'(1);
        end
        else
        begin
            rem_next[0] = DEN_W'(in_state.a);
            quo_next[0] = '0;
        end
        shifted = '0;
        for (int i = 1; i < W_W; i++)
        begin
            shifted = {rem_reg[i-1], 1'b0};
            if (shifted >= (DEN_W+1)'(den_reg[i-1]))
            begin
                rem_next[i] = DEN_W'(shifted - (DEN_W+1)'(den_reg[i-1]));
                quo_next[i] = {quo_reg[i-1][W_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = DEN_W'(shifted);
                quo_next[i] = {quo_reg[i-1][W_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[W_W-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= den0;
        dz_reg[0]  <= (den0 == '0);
        car_reg[0] <= in_state.carry;
        for (int i = 0; i < W_W; i++)
        begin
            rem_reg[i] <= rem_next[i];
            quo_reg[i] <= quo_next[i];
        end
        for (int i = 1; i < W_W; i++)
        begin
            den_reg[i] <= den_reg[i-1];
            dz_reg[i]  <= dz_reg[i-1];
            car_reg[i] <= car_reg[i-1];
        end
    end

    assign out_valid = v_reg[W_W-1];
    assign weight    = dz_reg[W_W-1] ? '0 : quo_reg[W_W-1];
    assign out_carry = car_reg[W_W-1];

endmodule

FILE: hdl/bwe_apply.sv
// ----------------------------------------------------------------------------
// bwe_apply
// Gain interpolation, clamp, sample multiply and saturation.
// ----------------------------------------------------------------------------
module bwe_apply
    import bwe_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [W_W-1:0] weight,
    input  carry_t         in_carry,
    input  cfg_t           cfg,
    output logic           result_strobe,
    output result_t        result
);

    localparam int MW_W = GPCT_W + W_W;
    localparam int SP_W = WORD_W + GAIN_W;
    localparam int PR_W = SP_W - FRAC_BITS;

    logic [3:0]          v_reg;
    logic                up_reg;
    logic [MW_W-1:0]     mw_reg;
    carry_t              c1_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [GAIN_W-1:0]   gain_next;
    logic [WORD_W-1:0]   s2_reg;
    logic [SP_W-1:0]     sp_reg;
    logic                up;
    logic [GPCT_W-1:0]   span;
    logic [GPCT_W:0]     delta;
    logic [GPCT_W:0]     g_wide;
    logic [PR_W-1:0]     scaled;
    result_t             res_reg;
    result_t             res_next;

    always_comb
    begin
        up   = cfg.gain_high >= cfg.gain_low;
        span = up ? cfg.gain_high - cfg.gain_low : cfg.gain_low - cfg.gain_high;
    end

    always_comb
    begin
        delta = (GPCT_W+1)'(mw_reg >> FRAC_BITS);
        if (c1_reg.d_zero)
            g_wide = (GPCT_W+1)'(cfg.gain_low);
        else if (up_reg)
            g_wide = (GPCT_W+1)'(cfg.gain_low) + delta;
        else
            g_wide = (GPCT_W+1)'(cfg.gain_low) - delta;
        gain_next = (g_wide > (GPCT_W+1)'(GAIN_MAX)) ? GAIN_MAX : GAIN_W'(g_wide);
    end

    always_comb
    begin
        scaled = PR_W'(sp_reg >> FRAC_BITS);
        if (scaled > PR_W'({WORD_W{1'b1}}))
        begin
            res_next.filtered_value = '1;
            res_next.saturated      = 1'b1;
        end
        else
        begin
            res_next.filtered_value = WORD_W'(scaled);
            res_next.saturated      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        up_reg   <= up;
        mw_reg   <= MW_W'(span) * MW_W'(weight);
        c1_reg   <= in_carry;
        gain_reg <= gain_next;
        s2_reg   <= c1_reg.sample;
        sp_reg   <= SP_W'(s2_reg) * SP_W'(gain_reg);
        res_reg  <= res_next;
    end

    assign result_strobe = v_reg[3];
    assign result        = res_reg;

endmodule

FILE: hdl/butterworth_emphasis_gain_multiply.sv
// ----------------------------------------------------------------------------
// butterworth_emphasis_gain_multiply
// Butterworth high-emphasis gain applied to one spectrum sample per request.
// ----------------------------------------------------------------------------
// Path: input register, distance stages, weight power steps, divider, then gain and product registers.
// Throughput: one request per cycle; busy stays low, every stage is a register.
// Depth is set by 15 weight power steps (two stages each) and a 17-stage divider.
// Reset: asynchronous, clears valid bits and loads default settings.
// The result is shown for one cycle; the receiver cannot stall.
module butterworth_emphasis_gain_multiply
    import bwe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output logic             result_strobe,
    output result_t          result
);

    cfg_t           cfg;
    logic           accept;
    logic           v_step [NUM_STEPS+1];
    wstate_t        st_step [NUM_STEPS+1];
    logic           div_valid;
    logic [W_W-1:0] weight;
    carry_t         div_carry;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    bwe_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bwe_dist u_dist
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg       (cfg),
        .out_valid (v_step[0]),
        .out_state (st_step[0])
    );

    for (genvar k = 0; k < NUM_STEPS; k++)
    begin : g_step
        bwe_wstep #(.STEP(k)) u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_step[k]),
            .in_state  (st_step[k]),
            .order     (cfg.order),
            .cut_sq    (cfg.cut_sq),
            .out_valid (v_step[k+1]),
            .out_state (st_step[k+1])
        );
    end

    bwe_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_step[NUM_STEPS]),
        .in_state  (st_step[NUM_STEPS]),
        .out_valid (div_valid),
        .weight    (weight),
        .out_carry (div_carry)
    );

    bwe_apply u_apply
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (div_valid),
        .weight        (weight),
        .in_carry      (div_carry),
        .cfg           (cfg),
        .result_strobe (result_strobe),
        .result        (result)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY result_strobe)
        else $error("request did not produce a result on time");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(accept, LATENCY))
        else $error("result without a matching request");

    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.saturated) |-> (result.filtered_value == '1))
        else $error("saturated result not clamped");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid |-> (weight <= W_W'(1 << FRAC_BITS)))
        else $error("weight above unity");

endmodule

FILE: tb/butterworth_emphasis_gain_multiply_tb.sv
// ----------------------------------------------------------------------------
// butterworth_emphasis_gain_multiply_tb
// Streams spectrum samples through the emphasis gain block under a series of
// filter settings. Each accepted request is predicted in the bench and
// checked, field by field, against the result strobed out.
// ----------------------------------------------------------------------------
module butterworth_emphasis_gain_multiply_tb
    import bwe_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;

    // indexes with no register behind them
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    item_t            item;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [2:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             result_strobe;
    result_t          result;

    butterworth_emphasis_gain_multiply dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_strobe(result_strobe),
        .result       (result)
    );

    // settings as the block sees them
    logic [CFG_W-1:0] set_rows, set_cols, set_cut;
    logic [ORD_W-1:0] set_order;
    logic [PCT_W-1:0] set_high, set_low;

    item_t   pending_samples[$];
    result_t filtered_expected[$];
    int      accepted_count;
    int      cfg_write_count;
    int      cycle_count;
    bit      failed;
    int      gap_left;

    // cleared at the edge that takes a request, set again at any edge that takes none
    bit busy_seen;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint unsigned pct_gain(input logic [PCT_W-1:0] pct);
        return ((longint'(pct) << FRAC_BITS) + 50) / 100;
    endfunction

    function automatic longint unsigned axis_sq(input logic [IDX_W-1:0] idx,
                                                input logic [CFG_W-1:0] dim);
        longint unsigned centre;
        longint unsigned diff;
        centre = ((dim > MAX_DIM) ? MAX_DIM : dim) / 2;
        diff = (idx >= centre) ? idx - centre : centre - idx;
        return diff * diff;
    endfunction

    function automatic result_t emphasize(input item_t it);
        longint unsigned gh, gl, d, q, a, b, w, gain, prod;
        result_t r;
        gh = pct_gain(set_high);
        gl = pct_gain(set_low);
        d  = axis_sq(it.row_index, set_rows) + axis_sq(it.col_index, set_cols);
        q  = longint'(set_cut) * longint'(set_cut);
        if (d == 0)
        begin
            gain = gl;
        end
        else
        begin
            a = 1;
            b = 1;
            for (int k = 0; k < set_order; k++)
            begin
                a = a * d;
                b = b * q;
                while (a >= 64'h1_0000_0000 || b >= 64'h1_0000_0000)
                begin
                    a = a >> 1;
                    b = b >> 1;
                end
            end
            w = (a + b == 0) ? 0 : (a << FRAC_BITS) / (a + b);
            if (gh >= gl)
                gain = gl + (((gh - gl) * w) >> FRAC_BITS);
            else
                gain = gl - (((gl - gh) * w) >> FRAC_BITS);
        end
        if (gain > GAIN_MAX)
            gain = GAIN_MAX;
        prod = (longint'(it.spectrum_value) * gain) >> FRAC_BITS;
        if (prod > 64'hFFFF_FFFF)
        begin
            r.filtered_value = 32'hFFFF_FFFF;
            r.saturated = 1'b1;
        end
        else
        begin
            r.filtered_value = prod[31:0];
            r.saturated = 1'b0;
        end
        return r;
    endfunction

    // driver: one request at a time, random gaps between them
    always @(negedge clk)
    begin
        logic  nxt_start;
        item_t nxt_item;
        int    roll;
        nxt_start = start;
        nxt_item = item;
        if (!rst_n)
        begin
            nxt_start = 1'b0;
        end
        else if (!start || accepted_count > 0 && start && !busy_seen)
        begin
            nxt_start = 1'b0;
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
            end
            else if (pending_samples.size() > 0)
            begin
                nxt_item = pending_samples.pop_front();
                nxt_start = 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    gap_left = 0;
                else if (roll < 94)
                    gap_left = $urandom_range(1, 3);
                else
                    gap_left = $urandom_range(10, 40);
            end
        end
        start <= nxt_start;
        item <= nxt_item;
    end

    // monitor: requests, setting writes and results, all at the rising edge
    always @(posedge clk)
    begin
        result_t want;
        cycle_count <= cycle_count + 1;
        busy_seen <= !(rst_n && start && !busy);
        if (rst_n)
        begin
            if (result_strobe)
            begin
                if (filtered_expected.size() == 0)
                begin
                    $display("%0t: result with no request outstanding: value %h sat %b",
                             $time, result.filtered_value, result.saturated);
                    failed <= 1'b1;
                end
                else
                begin
                    want = filtered_expected.pop_front();
                    if (result.filtered_value !== want.filtered_value)
                    begin
                        $display("%0t: filtered_value expected %h actual %h", $time,
                                 want.filtered_value, result.filtered_value);
                        failed <= 1'b1;
                    end
                    if (result.saturated !== want.saturated)
                    begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, result.saturated);
                        failed <= 1'b1;
                    end
                end
            end
            if (start && !busy)
            begin
                filtered_expected.push_back(emphasize(item));
                accepted_count <= accepted_count + 1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROWS:  set_rows <= cfg_data;
                    REG_COLS:  set_cols <= cfg_data;
                    REG_CUT:   set_cut <= cfg_data;
                    REG_ORDER: set_order <= cfg_data[ORD_W-1:0];
                    REG_HIGH:  set_high <= cfg_data[PCT_W-1:0];
                    REG_LOW:   set_low <= cfg_data[PCT_W-1:0];
                    default: ;
                endcase
                cfg_write_count <= cfg_write_count + 1;
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_setting(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        int target;
        target = cfg_write_count + 1;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        wait (cfg_write_count == target);
    endtask

    task automatic load_settings(input int rows, input int cols, input int cut,
                                 input int order, input int high, input int low);
        write_setting(REG_ROWS, CFG_W'(rows));
        write_setting(REG_COLS, CFG_W'(cols));
        write_setting(REG_CUT, CFG_W'(cut));
        write_setting(REG_ORDER, CFG_W'(order));
        write_setting(REG_HIGH, CFG_W'(high));
        write_setting(REG_LOW, CFG_W'(low));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        wait (pending_samples.size() == 0 && filtered_expected.size() == 0 &&
              !(start && gap_left >= 0 && busy_seen == 1'b0));
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    function automatic item_t make_sample(input int r, input int c, input logic [31:0] v);
        item_t it;
        it.row_index = IDX_W'(r);
        it.col_index = IDX_W'(c);
        it.spectrum_value = v;
        return it;
    endfunction

    task automatic queue_random(input int n);
        item_t it;
        int    mode;
        repeat (n)
        begin
            it.row_index = IDX_W'($urandom);
            it.col_index = IDX_W'($urandom);
            // cluster some near the centre, where the weight actually moves
            if ($urandom_range(0, 2) == 0)
            begin
                it.row_index = IDX_W'(((set_rows > MAX_DIM) ? MAX_DIM : set_rows) / 2
                               + $urandom_range(0, 24) - 12);
                it.col_index = IDX_W'(((set_cols > MAX_DIM) ? MAX_DIM : set_cols) / 2
                               + $urandom_range(0, 24) - 12);
            end
            mode = $urandom_range(0, 3);
            case (mode)
                0: it.spectrum_value = $urandom_range(0, 16'hFFFF);
                1: it.spectrum_value = $urandom >> $urandom_range(0, 31);
                default: it.spectrum_value = $urandom;
            endcase
            pending_samples.push_back(it);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_ROWS;
        cfg_data = '0;
        failed = 1'b0;
        accepted_count = 0;
        cfg_write_count = 0;
        cycle_count = 0;
        gap_left = 0;
        busy_seen = 1'b1;
        set_rows = ROWS_RST;
        set_cols = COLS_RST;
        set_cut = CUT_RST;
        set_order = ORDER_RST;
        set_high = HIGH_RST;
        set_low = LOW_RST;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, under reset settings
        pending_samples.push_back(make_sample(256, 256, 32'h0001_0000)); // centre
        pending_samples.push_back(make_sample(256, 256, 32'hFFFF_FFFF));
        pending_samples.push_back(make_sample(0, 0, 32'hFFFF_FFFF));
        pending_samples.push_back(make_sample(1023, 1023, 32'hFFFF_FFFF));
        pending_samples.push_back(make_sample(0, 1023, 32'h0000_0000));
        pending_samples.push_back(make_sample(266, 256, 32'h0001_0000)); // at cutoff
        pending_samples.push_back(make_sample(257, 256, 32'h0001_0000));
        pending_samples.push_back(make_sample(256, 255, 32'h8000_0000));
        pending_samples.push_back(make_sample(1023, 0, 32'h0000_0001));
        pending_samples.push_back(make_sample(600, 400, 32'h5555_AAAA));
        drain();

        // tiny image, low far above high, index outside image
        load_settings(2, 2, 1, 1, 0, 400);
        pending_samples.push_back(make_sample(1, 1, 32'hFFFF_FFFF));
        pending_samples.push_back(make_sample(1023, 1023, 32'hFFFF_FFFF));
        pending_samples.push_back(make_sample(2, 1, 32'h0004_0000));
        queue_random(80);
        drain();

        // oversized dims, zero cutoff, biggest gains (clamped), highest order
        write_setting(REG_SPARE_A, 11'h7FF);
        write_setting(REG_SPARE_B, 11'h000);
        load_settings(2047, 1024, 0, 15, 511, 511);
        pending_samples.push_back(make_sample(512, 512, 32'hFFFF_FFFF));
        pending_samples.push_back(make_sample(513, 512, 32'h0001_0000));
        queue_random(80);
        drain();

        // zero order, high gain, large cutoff
        load_settings(1024, 2, 2047, 0, 400, 0);
        pending_samples.push_back(make_sample(512, 1, 32'h0001_0000));
        pending_samples.push_back(make_sample(0, 1023, 32'hFFFF_FFFF));
        queue_random(90);
        drain();

        // odd dims, mid settings, order 8
        load_settings(777, 301, 37, 8, 250, 20);
        queue_random(90);
        drain();

        load_settings(64, 1000, 5, 3, 150, 170);
        queue_random(90);
        drain();

        for (int p = 0; p < 2; p++)
        begin
            load_settings($urandom_range(2, 2047), $urandom_range(2, 2047),
                          $urandom_range(0, 2047), $urandom_range(0, 15),
                          $urandom_range(0, 511), $urandom_range(0, 511));
            queue_random(60);
            drain();
        end

        if (!failed)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
